// ----- hw/rtl/aarm_pkg.sv -----
// Shared types and constants for the axis-angle to rotation matrix pipeline.
package aarm_pkg;

   localparam int Q = 30;
   localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
   localparam int CORDIC_STEPS = 30;
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS = 32;

   function automatic logic [31:0] atan_entry(input int idx);
      logic [31:0] r;
      case (idx)
         0: r = 32'd536870912;
         1: r = 32'd316933406;
         2: r = 32'd167458907;
         3: r = 32'd85004756;
         4: r = 32'd42667331;
         5: r = 32'd21354465;
         6: r = 32'd10679838;
         7: r = 32'd5340245;
         8: r = 32'd2670163;
         9: r = 32'd1335087;
         10: r = 32'd667544;
         11: r = 32'd333772;
         12: r = 32'd166886;
         13: r = 32'd83443;
         14: r = 32'd41722;
         15: r = 32'd20861;
         16: r = 32'd10430;
         17: r = 32'd5215;
         18: r = 32'd2608;
         19: r = 32'd1304;
         20: r = 32'd652;
         21: r = 32'd326;
         22: r = 32'd163;
         23: r = 32'd81;
         24: r = 32'd41;
         25: r = 32'd20;
         26: r = 32'd10;
         27: r = 32'd5;
         28: r = 32'd3;
         29: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   // Q1.30 product with round half up (floor shift).
   function automatic logic signed [32:0] mulq(input logic signed [32:0] p,
                                               input logic signed [32:0] q);
      logic signed [65:0] pr;
      pr = 66'(p) * 66'(q) + 66'sd536870912;
      return 33'(pr >>> Q);
   endfunction

   function automatic logic signed [32:0] sat_q30(input logic signed [35:0] x);
      logic signed [32:0] r;
      if (x > 36'(ONE_Q30)) r = ONE_Q30;
      else if (x < -36'(ONE_Q30)) r = -ONE_Q30;
      else r = 33'(x);
      return r;
   endfunction

   typedef struct packed {
      logic               zero;
      logic [2:0]         neg;
      logic [31:0]        mag_x;
      logic [31:0]        mag_y;
      logic [31:0]        mag_z;
   } axis_norm_type;

endpackage

// ----- hw/rtl/aarm_cordic.sv -----
// Pipelined CORDIC: one rotation step per stage, gives cos and sin in Q1.30.
module aarm_cordic (
   input  logic                clock,
   input  logic                advance,
   input  logic [31:0]         angle,
   output logic signed [32:0]  cos_q,
   output logic signed [32:0]  sin_q
);
   logic signed [33:0] x_ff [0:aarm_pkg::CORDIC_STEPS];
   logic signed [33:0] y_ff [0:aarm_pkg::CORDIC_STEPS];
   logic signed [33:0] z_ff [0:aarm_pkg::CORDIC_STEPS];
   logic               flip_ff [0:aarm_pkg::CORDIC_STEPS];
   logic signed [33:0] z_in;
   logic               flip_in;

   always_comb begin
      z_in = 34'(signed'(angle));
      flip_in = 1'b0;
      if (z_in > 34'sd1073741824) begin
         z_in = z_in - 34'sd2147483648;
         flip_in = 1'b1;
      end else if (z_in < -34'sd1073741824) begin
         z_in = z_in + 34'sd2147483648;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0] <= aarm_pkg::CORDIC_X0;
         y_ff[0] <= '0;
         z_ff[0] <= z_in;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < aarm_pkg::CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (advance) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - 34'(aarm_pkg::atan_entry(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + 34'(aarm_pkg::atan_entry(i));
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   always_comb begin
      logic signed [35:0] xf, yf;
      xf = 36'(x_ff[aarm_pkg::CORDIC_STEPS]);
      yf = 36'(y_ff[aarm_pkg::CORDIC_STEPS]);
      if (flip_ff[aarm_pkg::CORDIC_STEPS]) begin
         xf = -xf;
         yf = -yf;
      end
      cos_q = aarm_pkg::sat_q30(xf);
      sin_q = aarm_pkg::sat_q30(yf);
   end
endmodule

// ----- hw/rtl/aarm_sqrt.sv -----
// Pipelined rounded integer square root of a 64-bit sum, one result bit per stage.
module aarm_sqrt (
   input  logic        clock,
   input  logic        advance,
   input  logic [63:0] sum,
   output logic [32:0] root
);
   localparam int N = aarm_pkg::SQRT_STEPS;
   logic [63:0] rem_ff [0:N];
   logic [32:0] r_ff [0:N];

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= sum;
         r_ff[0] <= '0;
      end
   end

   // Restoring root: step k decides bit (N-1-k) of the root.
   for (genvar k = 0; k < N; k++) begin : g_bit
      localparam int B = N - 1 - k;
      always_ff @(posedge clock) begin
         logic [65:0] trial;
         trial = (66'(r_ff[k]) << (B + 1)) + (66'd1 << (2 * B));
         if (advance) begin
            if (66'(rem_ff[k]) >= trial) begin
               rem_ff[k+1] <= 64'(66'(rem_ff[k]) - trial);
               r_ff[k+1] <= r_ff[k] | (33'd1 << B);
            end else begin
               rem_ff[k+1] <= rem_ff[k];
               r_ff[k+1] <= r_ff[k];
            end
         end
      end
   end

   // Round: remainder s - r*r above r means nearer to r+1.
   assign root = (rem_ff[N] > 64'(r_ff[N])) ? r_ff[N] + 33'd1 : r_ff[N];
endmodule

// ----- hw/rtl/aarm_div.sv -----
// Pipelined restoring divider: (mag * 2^30 + d/2) / d, one quotient bit per stage.
module aarm_div (
   input  logic        clock,
   input  logic        advance,
   input  logic [31:0] mag,
   input  logic [32:0] den,
   output logic [31:0] quo
);
   localparam int N = aarm_pkg::DIV_STEPS;
   logic [62:0] num_ff [0:N];
   logic [32:0] d_ff [0:N];
   logic [33:0] rem_ff [0:N];
   logic [31:0] q_ff [0:N];

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff[0] <= (63'(mag) << 30) + 63'(den >> 1);
         d_ff[0] <= den;
         rem_ff[0] <= '0;
         q_ff[0] <= '0;
      end
   end

   // Numerator stays below 2^63; quotient fits 32 bits, so the top 32 bits
   // are handled in the first stage as a partial remainder.
   for (genvar k = 0; k < N; k++) begin : g_bit
      localparam int B = N - 1 - k;
      always_ff @(posedge clock) begin
         logic [65:0] r;
         if (k == 0) r = 66'(num_ff[k] >> (B));
         else r = {32'(rem_ff[k]), num_ff[k][B]};
         if (advance) begin
            num_ff[k+1] <= num_ff[k];
            d_ff[k+1] <= d_ff[k];
            if (r >= 66'(d_ff[k])) begin
               rem_ff[k+1] <= 34'(r - 66'(d_ff[k]));
               q_ff[k+1] <= q_ff[k] | (32'd1 << B);
            end else begin
               rem_ff[k+1] <= 34'(r);
               q_ff[k+1] <= q_ff[k];
            end
         end
      end
   end

   assign quo = q_ff[N];
endmodule

// ----- hw/rtl/axis_angle_to_rotation_matrix_top.sv -----
// Pipeline stages from request accept to result: front 2, sqrt 33, divide 33, matrix 2.
// Throughput: one request per cycle unless the result stalls; all stages are plain registers advanced together.
// A stall at the result holds the whole pipeline; ready follows rsp_tready directly
// and is high while the output stage is empty or being taken.
// Reset: synchronous, active high, clears valid bits only; no clearing pass.
// Zero axis overrides the arithmetic and gives the identity with axis_zero set.
module axis_angle_to_rotation_matrix_top #(
   parameter int AXIS_BITS = 24,
   parameter int ANGLE_BITS = 32,
   parameter int OUT_FRAC_BITS = 30
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // axis_x, axis_y, axis_z, angle from bit 0 up, zero-padded to bytes
   input  logic [((3*AXIS_BITS+ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
   output logic [287:0] rsp_tdata,
   // axis_zero
   output logic         rsp_tuser
);
   localparam int FRONT = 2;
   localparam int SQ = aarm_pkg::SQRT_STEPS + 1;
   localparam int DV = aarm_pkg::DIV_STEPS + 1;
   localparam int LAT = FRONT + SQ + DV + 2;
   localparam int SH_OUT = 30 - OUT_FRAC_BITS;
   localparam int CD = LAT - 2 - (aarm_pkg::CORDIC_STEPS + 1);

   logic advance;
   logic [LAT-1:0] valid_ff;
   assign advance = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (advance) valid_ff <= {valid_ff[LAT-2:0], req_tvalid};
   end

   // ---- unpack and normalize stage 0: sign-extend, find common shift
   logic signed [AXIS_BITS-1:0] ax_x, ax_y, ax_z;
   logic [31:0] ang32;
   assign ax_x = req_tdata[AXIS_BITS-1:0];
   assign ax_y = req_tdata[2*AXIS_BITS-1:AXIS_BITS];
   assign ax_z = req_tdata[3*AXIS_BITS-1:2*AXIS_BITS];
   assign ang32 = 32'(req_tdata[3*AXIS_BITS+ANGLE_BITS-1:3*AXIS_BITS]) << (32 - ANGLE_BITS);

   logic [31:0] mag0_ff [0:2];
   logic [2:0] neg0_ff;
   logic [5:0] sh0_ff;
   logic zero0_ff;

   always_ff @(posedge clock) begin
      logic [31:0] m [0:2];
      logic [31:0] mx;
      logic [5:0] s;
      mx = '0;
      for (int i = 0; i < 3; i++) begin
         logic signed [31:0] c;
         c = (i == 0) ? 32'(ax_x) : (i == 1) ? 32'(ax_y) : 32'(ax_z);
         m[i] = c[31] ? 32'(-c) : 32'(c);
         if (m[i] > mx) mx = m[i];
      end
      // Shift that brings the top set bit of the largest magnitude up to bit 30
      s = '0;
      for (int b = 0; b < 30; b++) if (mx[b]) s = 6'(30 - b);
      if (mx[31] || mx[30]) s = '0;
      if (advance) begin
         for (int i = 0; i < 3; i++) mag0_ff[i] <= m[i];
         neg0_ff <= {ax_z[AXIS_BITS-1], ax_y[AXIS_BITS-1], ax_x[AXIS_BITS-1]};
         sh0_ff <= s;
         zero0_ff <= (mx == 32'd0);
      end
   end

   // ---- stage 1: shift and sum of squares
   aarm_pkg::axis_norm_type nrm_ff;
   logic [63:0] sum_ff;
   always_ff @(posedge clock) begin
      logic [31:0] sm [0:2];
      for (int i = 0; i < 3; i++) sm[i] = mag0_ff[i] << sh0_ff;
      if (advance) begin
         nrm_ff.zero <= zero0_ff;
         nrm_ff.neg <= neg0_ff;
         nrm_ff.mag_x <= sm[0];
         nrm_ff.mag_y <= sm[1];
         nrm_ff.mag_z <= sm[2];
         sum_ff <= 64'(sm[0]) * 64'(sm[0]) + 64'(sm[1]) * 64'(sm[1])
                   + 64'(sm[2]) * 64'(sm[2]);
      end
   end

   logic [32:0] root;
   aarm_sqrt u_sqrt (.clock(clock), .advance(advance), .sum(sum_ff), .root(root));

   // Delay normalized axis alongside the square root.
   aarm_pkg::axis_norm_type nd_ff [0:SQ-1];
   always_ff @(posedge clock) begin
      if (advance) begin
         nd_ff[0] <= nrm_ff;
         for (int i = 1; i < SQ; i++) nd_ff[i] <= nd_ff[i-1];
      end
   end

   logic [31:0] q_x, q_y, q_z;
   aarm_div u_div_x (.clock(clock), .advance(advance), .mag(nd_ff[SQ-1].mag_x),
                     .den(root), .quo(q_x));
   aarm_div u_div_y (.clock(clock), .advance(advance), .mag(nd_ff[SQ-1].mag_y),
                     .den(root), .quo(q_y));
   aarm_div u_div_z (.clock(clock), .advance(advance), .mag(nd_ff[SQ-1].mag_z),
                     .den(root), .quo(q_z));

   logic [3:0] fl_ff [0:DV-1];
   always_ff @(posedge clock) begin
      if (advance) begin
         fl_ff[0] <= {nd_ff[SQ-1].zero, nd_ff[SQ-1].neg};
         for (int i = 1; i < DV; i++) fl_ff[i] <= fl_ff[i-1];
      end
   end

   // ---- angle path: delay, then CORDIC timed to meet the unit vector
   logic [31:0] ang_ff [0:CD-1];
   always_ff @(posedge clock) begin
      if (advance) begin
         ang_ff[0] <= ang32;
         for (int i = 1; i < CD; i++) ang_ff[i] <= ang_ff[i-1];
      end
   end
   logic signed [32:0] cs, sn;
   aarm_cordic u_cordic (.clock(clock), .advance(advance),
                         .angle(ang_ff[CD-1]), .cos_q(cs), .sin_q(sn));

   // ---- matrix stage A: unit vector and first products
   logic signed [32:0] u_ff, v_ff, w_ff, sn_ff, c1_ff;
   logic signed [32:0] uu_ff, vv_ff, ww_ff, uv_ff, uw_ff, vw_ff;
   logic za_ff;
   always_ff @(posedge clock) begin
      logic signed [32:0] u, v, w;
      u = (q_x > 32'd1073741824) ? aarm_pkg::ONE_Q30 : 33'(q_x);
      v = (q_y > 32'd1073741824) ? aarm_pkg::ONE_Q30 : 33'(q_y);
      w = (q_z > 32'd1073741824) ? aarm_pkg::ONE_Q30 : 33'(q_z);
      if (fl_ff[DV-1][0]) u = -u;
      if (fl_ff[DV-1][1]) v = -v;
      if (fl_ff[DV-1][2]) w = -w;
      if (advance) begin
         u_ff <= u; v_ff <= v; w_ff <= w;
         sn_ff <= sn;
         c1_ff <= aarm_pkg::ONE_Q30 - cs;
         uu_ff <= aarm_pkg::mulq(u, u);
         vv_ff <= aarm_pkg::mulq(v, v);
         ww_ff <= aarm_pkg::mulq(w, w);
         uv_ff <= aarm_pkg::mulq(u, v);
         uw_ff <= aarm_pkg::mulq(u, w);
         vw_ff <= aarm_pkg::mulq(v, w);
         za_ff <= fl_ff[DV-1][3];
      end
   end

   // ---- matrix stage B: second products, sums, saturate, round into output
   function automatic logic [31:0] to_out(input logic signed [35:0] x);
      logic signed [32:0] s;
      logic signed [33:0] r;
      s = aarm_pkg::sat_q30(x);
      r = 34'(s);
      if (SH_OUT > 0) r = (r + (34'sd1 <<< (SH_OUT - 1))) >>> SH_OUT;
      return 32'(r);
   endfunction

   logic [287:0] mat_ff;
   logic zo_ff;
   always_ff @(posedge clock) begin
      logic signed [32:0] a, b, c, us, vs, ws, d0, d1, d2;
      logic [31:0] e [0:8];
      a = aarm_pkg::mulq(uv_ff, c1_ff);
      b = aarm_pkg::mulq(uw_ff, c1_ff);
      c = aarm_pkg::mulq(vw_ff, c1_ff);
      us = aarm_pkg::mulq(u_ff, sn_ff);
      vs = aarm_pkg::mulq(v_ff, sn_ff);
      ws = aarm_pkg::mulq(w_ff, sn_ff);
      d0 = aarm_pkg::mulq(aarm_pkg::ONE_Q30 - uu_ff, c1_ff);
      d1 = aarm_pkg::mulq(aarm_pkg::ONE_Q30 - vv_ff, c1_ff);
      d2 = aarm_pkg::mulq(aarm_pkg::ONE_Q30 - ww_ff, c1_ff);
      e[0] = to_out(36'(aarm_pkg::ONE_Q30) - 36'(d0));
      e[1] = to_out(36'(a) - 36'(ws));
      e[2] = to_out(36'(b) + 36'(vs));
      e[3] = to_out(36'(a) + 36'(ws));
      e[4] = to_out(36'(aarm_pkg::ONE_Q30) - 36'(d1));
      e[5] = to_out(36'(c) - 36'(us));
      e[6] = to_out(36'(b) - 36'(vs));
      e[7] = to_out(36'(c) + 36'(us));
      e[8] = to_out(36'(aarm_pkg::ONE_Q30) - 36'(d2));
      if (za_ff) begin
         for (int i = 0; i < 9; i++)
            e[i] = (i % 4 == 0) ? to_out(36'(aarm_pkg::ONE_Q30)) : 32'd0;
      end
      if (advance) begin
         for (int i = 0; i < 9; i++) mat_ff[32*i +: 32] <= e[i];
         zo_ff <= za_ff;
      end
   end

   assign rsp_tdata = mat_ff;
   assign rsp_tuser = zo_ff;

`ifndef ASSERT_OFF
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipeline stalled with empty output");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[31:0] == rsp_tdata[159:128])
      else $error("identity diagonal mismatch");
`endif
endmodule
